@@ rtl/assert_macros.svh @@
// Assertion macros shared by the slot manager RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define LLSM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define LLSM_ASSERT_NEXT(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/llsm_pkg.sv @@
// Shared constants, codes, port structs and helper functions of the slot manager.
// Depends on nothing.
package llsm_pkg;

   localparam int SLOT_COUNT  = 256;
   localparam int VALUE_BITS  = 32;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int STEP_BITS   = SLOT_BITS + 1;
   localparam int ACTION_BITS = 2;
   localparam int ANCHOR_BITS = 8;
   localparam int STATUS_BITS = 2;
   localparam int INPUT_BITS  = 32;

   localparam logic [ACTION_BITS-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_SEARCH = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_ANCHOR = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND  = 2'd3;

   // Port bundle of a link memory (next or previous pointers).
   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      logic [SLOT_BITS-1:0] wr_data;
      logic [SLOT_BITS-1:0] rd_addr;
   } link_port_type;

   // Port bundle of the slot data memory.
   typedef struct packed {
      logic                  wr_en;
      logic [SLOT_BITS-1:0]  wr_addr;
      logic [VALUE_BITS-1:0] wr_data;
      logic [SLOT_BITS-1:0]  rd_addr;
   } data_port_type;

   // Port bundle of the in-use flag memory.
   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      logic                 wr_data;
      logic [SLOT_BITS-1:0] rd_addr;
   } flag_port_type;

   // Input value to stored word: low bits kept, zero extended if wider.
   function automatic logic [VALUE_BITS-1:0] to_word(input logic [INPUT_BITS-1:0] v);
      logic [VALUE_BITS-1:0] w;
      for (int i = 0; i < VALUE_BITS; i++) begin
         w[i] = (i < INPUT_BITS) ? v[i % INPUT_BITS] : 1'b0;
      end
      return w;
   endfunction

   // Anchor field to slot index.
   function automatic logic [SLOT_BITS-1:0] to_index(input logic [ANCHOR_BITS-1:0] a);
      logic [SLOT_BITS-1:0] s;
      for (int i = 0; i < SLOT_BITS; i++) begin
         s[i] = (i < ANCHOR_BITS) ? a[i % ANCHOR_BITS] : 1'b0;
      end
      return s;
   endfunction

   // Slot index to the result field.
   function automatic logic [ANCHOR_BITS-1:0] to_field(input logic [SLOT_BITS-1:0] s);
      logic [ANCHOR_BITS-1:0] f;
      for (int i = 0; i < ANCHOR_BITS; i++) begin
         f[i] = (i < SLOT_BITS) ? s[i % SLOT_BITS] : 1'b0;
      end
      return f;
   endfunction

endpackage

@@ rtl/llsm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module llsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/llsm_ctrl.sv @@
// Sequencer of the slot manager: pointer registers, the shared key compare and
// the memory port control. Depends on llsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module llsm_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [llsm_pkg::ACTION_BITS-1:0]     req_action,
   input  logic [llsm_pkg::ANCHOR_BITS-1:0]     req_anchor_slot,
   input  logic [llsm_pkg::INPUT_BITS-1:0]      req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [llsm_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [llsm_pkg::ANCHOR_BITS-1:0]     rsp_result_slot,
   output llsm_pkg::link_port_type              nxt_port,
   output llsm_pkg::link_port_type              prv_port,
   output llsm_pkg::data_port_type              dat_port,
   output llsm_pkg::flag_port_type              use_port,
   input  logic [llsm_pkg::SLOT_BITS-1:0]       nxt_q,
   input  logic [llsm_pkg::SLOT_BITS-1:0]       prv_q,
   input  logic [llsm_pkg::VALUE_BITS-1:0]      dat_q,
   input  logic                                 use_q
);

   localparam int SB = llsm_pkg::SLOT_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_W2    = 3'd3;
   localparam logic [2:0] S_SRCH  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic [SB-1:0] LAST_SLOT = SB'(llsm_pkg::SLOT_COUNT - 1);
   localparam logic [llsm_pkg::STEP_BITS-1:0] STEP_LIMIT =
      llsm_pkg::STEP_BITS'(llsm_pkg::SLOT_COUNT);

   // Control state.
   logic [2:0]  state_ff, state_in;
   logic [SB-1:0] clr_ff, clr_in;
   logic [SB-1:0] head_ff, head_in;
   logic [SB-1:0] tail_ff, tail_in;
   logic [SB-1:0] free_ff, free_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Item working registers.
   logic [llsm_pkg::ACTION_BITS-1:0] act_ff, act_in;
   logic [SB-1:0]                    anc_ff, anc_in;
   logic                             anc_ok_ff, anc_ok_in;
   logic [llsm_pkg::VALUE_BITS-1:0]  key_ff, key_in;
   logic [SB-1:0]                    p_ff, p_in;
   logic [SB-1:0]                    s_ff, s_in;
   logic [SB-1:0]                    cur_ff, cur_in;
   logic [llsm_pkg::STEP_BITS-1:0]   steps_ff, steps_in;
   logic [llsm_pkg::STATUS_BITS-1:0] st_ff, st_in;
   logic [llsm_pkg::STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [llsm_pkg::ANCHOR_BITS-1:0] rsp_slot_ff, rsp_slot_in;

   logic          req_take;
   logic [SB-1:0] req_idx;
   logic          req_in_range;
   logic          key_hit;

   assign req_stall    = (state_ff != S_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign req_idx      = llsm_pkg::to_index(req_anchor_slot);
   assign req_in_range = (req_anchor_slot != '0) &&
                         (32'(req_anchor_slot) < 32'(llsm_pkg::SLOT_COUNT));

   // Shared compare unit: stored word of the current slot against the key.
   assign key_hit = (dat_q == key_ff);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      act_in        = act_ff;
      anc_in        = anc_ff;
      anc_ok_in     = anc_ok_ff;
      key_in        = key_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      nxt_port = '0;
      prv_port = '0;
      dat_port = '0;
      use_port = '0;

      // Read addresses: taken from the request in idle, from the chain in a search.
      if (state_ff == S_SRCH) begin
         nxt_port.rd_addr = nxt_q;
         dat_port.rd_addr = nxt_q;
      end else begin
         dat_port.rd_addr = head_ff;
         case (req_action)
            llsm_pkg::ACT_DELETE: nxt_port.rd_addr = req_idx;
            llsm_pkg::ACT_SEARCH: nxt_port.rd_addr = head_ff;
            default:              nxt_port.rd_addr = free_ff;
         endcase
      end
      prv_port.rd_addr = req_idx;
      use_port.rd_addr = req_idx;

      case (state_ff)
         // Build the free chain and clear the links after reset.
         S_CLEAR: begin
            nxt_port.wr_en   = 1'b1;
            nxt_port.wr_addr = clr_ff;
            nxt_port.wr_data = (clr_ff == LAST_SLOT) ? '0 : clr_ff + 1'b1;
            prv_port.wr_en   = 1'b1;
            prv_port.wr_addr = clr_ff;
            use_port.wr_en   = 1'b1;
            use_port.wr_addr = clr_ff;
            clr_in           = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_take) begin
               act_in    = req_action;
               anc_in    = req_idx;
               anc_ok_in = req_in_range;
               key_in    = llsm_pkg::to_word(req_value);
               cur_in    = head_ff;
               steps_in  = '0;
               state_in  = (req_action == llsm_pkg::ACT_SEARCH) ? S_SRCH : S_LOOK;
            end
         end

         // Reads are back: check the item and make the first round of writes.
         S_LOOK: begin
            st_in    = llsm_pkg::STATUS_OK;
            state_in = S_DONE;
            case (act_ff)
               llsm_pkg::ACT_APPEND: begin
                  if (free_ff == '0) begin
                     st_in = llsm_pkg::STATUS_FULL;
                  end else begin
                     dat_port.wr_en   = 1'b1;
                     dat_port.wr_addr = free_ff;
                     dat_port.wr_data = key_ff;
                     use_port.wr_en   = 1'b1;
                     use_port.wr_addr = free_ff;
                     use_port.wr_data = 1'b1;
                     nxt_port.wr_en   = 1'b1;
                     nxt_port.wr_addr = free_ff;
                     prv_port.wr_en   = 1'b1;
                     prv_port.wr_addr = free_ff;
                     prv_port.wr_data = tail_ff;
                     s_in    = free_ff;
                     p_in    = tail_ff;
                     free_in = nxt_q;
                     tail_in = free_ff;
                     if (tail_ff == '0) begin
                        head_in = free_ff;
                     end else begin
                        state_in = S_W2;
                     end
                  end
               end
               llsm_pkg::ACT_INSERT: begin
                  if (!(anc_ok_ff && use_q)) begin
                     st_in = llsm_pkg::STATUS_BAD_ANCHOR;
                  end else if (free_ff == '0) begin
                     st_in = llsm_pkg::STATUS_FULL;
                  end else begin
                     dat_port.wr_en   = 1'b1;
                     dat_port.wr_addr = free_ff;
                     dat_port.wr_data = key_ff;
                     use_port.wr_en   = 1'b1;
                     use_port.wr_addr = free_ff;
                     use_port.wr_data = 1'b1;
                     nxt_port.wr_en   = 1'b1;
                     nxt_port.wr_addr = free_ff;
                     nxt_port.wr_data = anc_ff;
                     prv_port.wr_en   = 1'b1;
                     prv_port.wr_addr = free_ff;
                     prv_port.wr_data = prv_q;
                     s_in     = free_ff;
                     p_in     = prv_q;
                     free_in  = nxt_q;
                     state_in = S_W2;
                     if (prv_q == '0) begin
                        head_in = free_ff;
                     end
                  end
               end
               llsm_pkg::ACT_DELETE: begin
                  if (!(anc_ok_ff && use_q)) begin
                     st_in = llsm_pkg::STATUS_BAD_ANCHOR;
                  end else begin
                     if (prv_q != '0) begin
                        nxt_port.wr_en   = 1'b1;
                        nxt_port.wr_addr = prv_q;
                        nxt_port.wr_data = nxt_q;
                     end else begin
                        head_in = nxt_q;
                     end
                     if (nxt_q != '0) begin
                        prv_port.wr_en   = 1'b1;
                        prv_port.wr_addr = nxt_q;
                        prv_port.wr_data = prv_q;
                     end else begin
                        tail_in = prv_q;
                     end
                     use_port.wr_en   = 1'b1;
                     use_port.wr_addr = anc_ff;
                     s_in     = anc_ff;
                     state_in = S_W2;
                  end
               end
               default: begin
                  st_in = llsm_pkg::STATUS_NOT_FOUND;
               end
            endcase
         end

         // Second round of link writes.
         S_W2: begin
            state_in = S_DONE;
            case (act_ff)
               llsm_pkg::ACT_APPEND: begin
                  nxt_port.wr_en   = 1'b1;
                  nxt_port.wr_addr = p_ff;
                  nxt_port.wr_data = s_ff;
               end
               llsm_pkg::ACT_INSERT: begin
                  nxt_port.wr_en   = (p_ff != '0);
                  nxt_port.wr_addr = p_ff;
                  nxt_port.wr_data = s_ff;
                  prv_port.wr_en   = 1'b1;
                  prv_port.wr_addr = anc_ff;
                  prv_port.wr_data = s_ff;
               end
               default: begin
                  nxt_port.wr_en   = 1'b1;
                  nxt_port.wr_addr = anc_ff;
                  nxt_port.wr_data = free_ff;
                  prv_port.wr_en   = 1'b1;
                  prv_port.wr_addr = anc_ff;
                  free_in          = anc_ff;
               end
            endcase
         end

         // One slot of the walk per cycle.
         S_SRCH: begin
            if (cur_ff == '0 || steps_ff == STEP_LIMIT) begin
               st_in    = llsm_pkg::STATUS_NOT_FOUND;
               state_in = S_DONE;
            end else if (key_hit) begin
               st_in    = llsm_pkg::STATUS_OK;
               s_in     = cur_ff;
               state_in = S_DONE;
            end else begin
               cur_in   = nxt_q;
               steps_in = steps_ff + 1'b1;
            end
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_slot_in   = (st_ff == llsm_pkg::STATUS_OK) ?
                               llsm_pkg::to_field(s_ff) : '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= SB'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      anc_ff        <= anc_in;
      anc_ok_ff     <= anc_ok_in;
      key_ff        <= key_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;

   // An empty list has neither head nor tail.
   `LLSM_ASSERT_ALWAYS(a_head_tail_empty, clock, reset,
      (state_ff != S_IDLE) || ((head_ff == '0) == (tail_ff == '0)),
      "list head and tail disagree on an empty list")
   // A successful append leaves a tail behind.
   `LLSM_ASSERT_NEXT(a_append_tail, clock, reset,
      (state_ff == S_LOOK) && (act_ff == llsm_pkg::ACT_APPEND) && (free_ff != '0),
      (tail_ff != '0), "append left no tail")
   // The search walk stays within the slot count.
   `LLSM_ASSERT_ALWAYS(a_walk_bound, clock, reset,
      (state_ff != S_SRCH) || (steps_ff <= STEP_LIMIT),
      "search walk ran past the slot count")

endmodule

@@ rtl/linked_list_slot_manager.sv @@
// Slot manager: append, insert and delete go through lookup, second write and
// done states (errors and an append to an empty list skip the second write),
// bound by the dependent link RAM reads and writes; a search walks the chain.
// After reset the block stalls while it builds the free chain in the link RAMs
// over all SLOT_COUNT (256) slots; the output register holds one result.
// Depends on llsm_pkg, llsm_ram and llsm_ctrl.
module linked_list_slot_manager (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [llsm_pkg::ACTION_BITS-1:0]        req_action,
   input  logic [llsm_pkg::ANCHOR_BITS-1:0]        req_anchor_slot,
   input  logic signed [llsm_pkg::INPUT_BITS-1:0]  req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [llsm_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [llsm_pkg::ANCHOR_BITS-1:0]        rsp_result_slot
);

   llsm_pkg::link_port_type nxt_port;
   llsm_pkg::link_port_type prv_port;
   llsm_pkg::data_port_type dat_port;
   llsm_pkg::flag_port_type use_port;

   logic [llsm_pkg::SLOT_BITS-1:0]  nxt_q;
   logic [llsm_pkg::SLOT_BITS-1:0]  prv_q;
   logic [llsm_pkg::VALUE_BITS-1:0] dat_q;
   logic                            use_q;

   // Sequencer.
   llsm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_anchor_slot (req_anchor_slot),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot),
      .nxt_port        (nxt_port),
      .prv_port        (prv_port),
      .dat_port        (dat_port),
      .use_port        (use_port),
      .nxt_q           (nxt_q),
      .prv_q           (prv_q),
      .dat_q           (dat_q),
      .use_q           (use_q)
   );

   // Forward links.
   llsm_ram #(.WIDTH(llsm_pkg::SLOT_BITS), .DEPTH(llsm_pkg::SLOT_COUNT)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_port.wr_en),
      .wr_addr (nxt_port.wr_addr),
      .wr_data (nxt_port.wr_data),
      .rd_addr (nxt_port.rd_addr),
      .rd_data (nxt_q)
   );

   // Backward links.
   llsm_ram #(.WIDTH(llsm_pkg::SLOT_BITS), .DEPTH(llsm_pkg::SLOT_COUNT)) u_prv_ram (
      .clock   (clock),
      .wr_en   (prv_port.wr_en),
      .wr_addr (prv_port.wr_addr),
      .wr_data (prv_port.wr_data),
      .rd_addr (prv_port.rd_addr),
      .rd_data (prv_q)
   );

   // Stored values.
   llsm_ram #(.WIDTH(llsm_pkg::VALUE_BITS), .DEPTH(llsm_pkg::SLOT_COUNT)) u_dat_ram (
      .clock   (clock),
      .wr_en   (dat_port.wr_en),
      .wr_addr (dat_port.wr_addr),
      .wr_data (dat_port.wr_data),
      .rd_addr (dat_port.rd_addr),
      .rd_data (dat_q)
   );

   // In-use flags.
   llsm_ram #(.WIDTH(1), .DEPTH(llsm_pkg::SLOT_COUNT)) u_use_ram (
      .clock   (clock),
      .wr_en   (use_port.wr_en),
      .wr_addr (use_port.wr_addr),
      .wr_data (use_port.wr_data),
      .rd_addr (use_port.rd_addr),
      .rd_data (use_q)
   );

endmodule
